@@ design/flba_pkg.sv @@
// types, codes and constants shared by the block pool allocator
package flba_pkg;

   localparam int unsigned INDEX_W    = 8;
   localparam int unsigned OFFSET_W   = 24;
   localparam int unsigned STATUS_W   = 2;
   localparam int unsigned STRIDE_W   = 11;
   localparam int unsigned UNIT_SHIFT = 6;
   localparam int unsigned STRIDE_MAX = 1024;

   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_GRANTED = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FREED   = 2'd2;

   typedef struct packed {
      logic               kind;
      logic [INDEX_W-1:0] block_index;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [INDEX_W-1:0]  granted_index;
      logic [OFFSET_W-1:0] byte_offset;
   } rsp_type;

   typedef struct packed {
      logic clr_en;
      logic take_req;
      logic finish_pop;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic rsp_busy;
      logic alloc_hit;
   } dp_stat_type;

endpackage

@@ design/flba_ctrl.sv @@
// controller state machine for the block pool allocator
module flba_ctrl
   import flba_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  dp_stat_type  stat,
   output ctrl_cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_IDLE  = 3'b010,
      ST_POP   = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_ready      = (state_ff == ST_IDLE) && !stat.rsp_busy;
   assign cmd.clr_en     = (state_ff == ST_CLEAR);
   assign cmd.take_req   = req_valid && req_ready;
   assign cmd.finish_pop = (state_ff == ST_POP);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (stat.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (cmd.take_req && stat.alloc_hit) begin
               state_in = ST_POP;
            end
         end
         ST_POP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ design/flba_datapath.sv @@
// head register, link memory, offset multiplier and response register
module flba_datapath
   import flba_pkg::*;
#(
   parameter int unsigned BLOCK_COUNT = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  ctrl_cmd_type        cmd,
   output dp_stat_type         stat,
   input  req_type             req,
   input  logic                csr_valid,
   input  logic [STRIDE_W-1:0] csr_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rsp_type             rsp
);

   localparam int unsigned IDX_W  = (BLOCK_COUNT > 2) ? $clog2(BLOCK_COUNT) : 1;
   localparam int unsigned LINK_W = IDX_W + 1;
   localparam int unsigned PROD_W = IDX_W + STRIDE_W;

   logic [LINK_W-1:0] link_mem [BLOCK_COUNT];

   logic [IDX_W-1:0]    clr_cnt_ff;
   logic [IDX_W-1:0]    clr_cnt_in;
   logic [IDX_W-1:0]    head_index_ff;
   logic [IDX_W-1:0]    head_index_in;
   logic                head_valid_ff;
   logic                head_valid_in;
   logic [STRIDE_W-1:0] stride_ff;
   logic [STRIDE_W-1:0] stride_in;
   logic [LINK_W-1:0]   link_rd_ff;
   logic [PROD_W-1:0]   product_ff;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   rsp_type             rsp_ff;
   rsp_type             rsp_in;
   logic                rsp_load;

   logic              free_hit;
   logic [IDX_W-1:0]  free_idx;
   logic [LINK_W-1:0] push_link;

   assign free_hit  = cmd.take_req && (req.kind == KIND_FREE)
                      && (32'(req.block_index) < 32'(BLOCK_COUNT));
   assign free_idx  = IDX_W'(req.block_index);
   assign push_link = head_valid_ff ? (LINK_W'(head_index_ff) + LINK_W'(1)) : '0;

   assign stat.clr_last  = (32'(clr_cnt_ff) == 32'(BLOCK_COUNT - 1));
   assign stat.rsp_busy  = rsp_valid_ff && !rsp_ready;
   assign stat.alloc_hit = (req.kind == KIND_ALLOC) && head_valid_ff;

   assign clr_cnt_in = cmd.clr_en ? (clr_cnt_ff + IDX_W'(1)) : clr_cnt_ff;

   always_comb begin
      stride_in = stride_ff;
      if (csr_valid) begin
         if (csr_data == '0) begin
            stride_in = STRIDE_W'(1);
         end else if (32'(csr_data) > STRIDE_MAX) begin
            stride_in = STRIDE_W'(STRIDE_MAX);
         end else begin
            stride_in = csr_data;
         end
      end
   end

   always_comb begin
      head_index_in = head_index_ff;
      head_valid_in = head_valid_ff;
      if (free_hit) begin
         head_index_in = free_idx;
         head_valid_in = 1'b1;
      end else if (cmd.finish_pop) begin
         if (link_rd_ff == '0) begin
            head_index_in = '0;
            head_valid_in = 1'b0;
         end else begin
            head_index_in = IDX_W'(link_rd_ff - LINK_W'(1));
         end
      end
   end

   always_comb begin
      rsp_load = 1'b0;
      rsp_in   = rsp_ff;
      if (cmd.take_req && (req.kind == KIND_FREE)) begin
         rsp_load = 1'b1;
         rsp_in   = '{status: STATUS_FREED, granted_index: '0, byte_offset: '0};
      end else if (cmd.take_req && !head_valid_ff) begin
         rsp_load = 1'b1;
         rsp_in   = '{status: STATUS_EMPTY, granted_index: '0, byte_offset: '0};
      end else if (cmd.finish_pop) begin
         rsp_load = 1'b1;
         rsp_in   = '{status:        STATUS_GRANTED,
                      granted_index: INDEX_W'(head_index_ff),
                      byte_offset:   OFFSET_W'({product_ff, UNIT_SHIFT'(0)})};
      end
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (cmd.clr_en) begin
         link_mem[clr_cnt_ff] <= LINK_W'(clr_cnt_ff);
      end else if (free_hit) begin
         link_mem[free_idx] <= push_link;
      end
      if (cmd.take_req) begin
         link_rd_ff <= link_mem[head_index_ff];
         product_ff <= PROD_W'(head_index_ff) * PROD_W'(stride_ff);
      end
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff    <= '0;
         head_index_ff <= IDX_W'(BLOCK_COUNT - 1);
         head_valid_ff <= 1'b1;
         stride_ff     <= STRIDE_W'(1);
         rsp_valid_ff  <= 1'b0;
      end else begin
         clr_cnt_ff    <= clr_cnt_in;
         head_index_ff <= head_index_in;
         head_valid_ff <= head_valid_in;
         stride_ff     <= stride_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

@@ design/free_list_block_allocator.sv @@
// top level of the fixed-size block pool allocator with a lifo free list
//
// requests arrive on req_valid/req_ready: kind selects allocate or free,
// block_index names the block to free. each request gives one response on
// rsp_valid/rsp_ready with a status, the granted index and its byte offset
// (index times stride times 64). csr_valid/csr_ready writes the block stride
// in 64-byte units; csr_ready is always high, write only while idle.
// a free or an allocate on an empty pool has its response registered at the
// accepting edge. an allocate registers the head's next link from the
// synchronous link memory at the accepting edge, then in the pop state the
// head moves and the response is loaded; no request is taken in the pop
// state. frees are accepted one per cycle while rsp_ready stays high.
// after reset a clearing pass writes the initial chain into the link memory,
// one entry per block, with req_ready low. the pool then holds every block,
// highest index first. a response waiting for rsp_ready holds its register;
// the next request is accepted in the cycle the response is taken.
module free_list_block_allocator
   import flba_pkg::*;
#(
   parameter int unsigned BLOCK_COUNT = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  req_type             req,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rsp_type             rsp,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [STRIDE_W-1:0] csr_data
);

   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   assign csr_ready = 1'b1;

   flba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   flba_datapath #(
      .BLOCK_COUNT (BLOCK_COUNT)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req       (req),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

endmodule

@@ design/flba_checker.sv @@
// port-level checks for the block pool allocator, bound to the top level
module flba_checker
   import flba_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
      else $error("response changed while stalled");

   a_no_grant_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp.status != STATUS_GRANTED)
         |-> (rsp.granted_index == '0) && (rsp.byte_offset == '0))
      else $error("nonzero fields without a grant");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp.status == STATUS_GRANTED) || (rsp.status == STATUS_EMPTY)
                    || (rsp.status == STATUS_FREED))
      else $error("unknown status code");

   a_free_resp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req.kind == KIND_FREE)
         |=> rsp_valid && (rsp.status == STATUS_FREED))
      else $error("free request without freed response");

endmodule

bind free_list_block_allocator flba_checker u_flba_checker (.*);

@@ test/tb_free_list_block_allocator.sv @@
// testbench for the block pool allocator: directed table, random bursts, lifo predictor
module tb_free_list_block_allocator;
   import flba_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned BLOCKS = 256;
   localparam int unsigned PHASE_REQUESTS = 200;

   typedef struct {
      logic                kind;
      logic [INDEX_W-1:0]  index;
      int unsigned         reps;
      bit                  typed;
      rsp_type             reply;
   } pool_op_row_type;

   localparam int unsigned OPENING_ROWS = 15;
   localparam int unsigned SCRIPT_ROWS  = 21;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   req_type             req = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   rsp_type             rsp;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [STRIDE_W-1:0] csr_data = '0;

   logic [STRIDE_W-1:0] stride_reg;
   logic [INDEX_W-1:0]  pool_head;
   logic                pool_has_free;
   logic [INDEX_W:0]    pool_link [BLOCKS];

   rsp_type             pending_replies [$];
   logic [INDEX_W-1:0]  held_blocks [$];
   int unsigned         send_idle_pct = 0;
   int unsigned         recv_stall_pct = 0;
   int unsigned         requests_sent = 0;
   int unsigned         mismatches = 0;

   // the last rows push blocks that are already free and leave a cycle in the list
   pool_op_row_type pool_script [SCRIPT_ROWS] = '{
      '{KIND_ALLOC, 8'h00, 1,   1'b1, {STATUS_GRANTED, 8'd255, 24'd16320}},
      '{KIND_FREE,  8'hFF, 1,   1'b1, {STATUS_FREED,   8'd0,   24'd0}},
      '{KIND_ALLOC, 8'hFF, 1,   1'b1, {STATUS_GRANTED, 8'd255, 24'd16320}},
      '{KIND_ALLOC, 8'h00, 254, 1'b0, '0},
      '{KIND_ALLOC, 8'h00, 1,   1'b1, {STATUS_GRANTED, 8'd0,   24'd0}},
      '{KIND_ALLOC, 8'h5A, 1,   1'b1, {STATUS_EMPTY,   8'd0,   24'd0}},
      '{KIND_ALLOC, 8'hA5, 1,   1'b1, {STATUS_EMPTY,   8'd0,   24'd0}},
      '{KIND_FREE,  8'h00, 1,   1'b1, {STATUS_FREED,   8'd0,   24'd0}},
      '{KIND_FREE,  8'hFF, 1,   1'b1, {STATUS_FREED,   8'd0,   24'd0}},
      '{KIND_ALLOC, 8'h33, 1,   1'b1, {STATUS_GRANTED, 8'd255, 24'd16320}},
      '{KIND_ALLOC, 8'hCC, 1,   1'b1, {STATUS_GRANTED, 8'd0,   24'd0}},
      '{KIND_ALLOC, 8'h00, 1,   1'b1, {STATUS_EMPTY,   8'd0,   24'd0}},
      '{KIND_FREE,  8'h5A, 1,   1'b1, {STATUS_FREED,   8'd0,   24'd0}},
      '{KIND_FREE,  8'hA5, 1,   1'b1, {STATUS_FREED,   8'd0,   24'd0}},
      '{KIND_ALLOC, 8'hFF, 1,   1'b0, '0},
      '{KIND_FREE,  8'h07, 1,   1'b1, {STATUS_FREED,   8'd0,   24'd0}},
      '{KIND_FREE,  8'h07, 1,   1'b1, {STATUS_FREED,   8'd0,   24'd0}},
      '{KIND_ALLOC, 8'h00, 3,   1'b0, '0},
      '{KIND_FREE,  8'hFF, 1,   1'b1, {STATUS_FREED,   8'd0,   24'd0}},
      '{KIND_FREE,  8'hFF, 1,   1'b1, {STATUS_FREED,   8'd0,   24'd0}},
      '{KIND_ALLOC, 8'h00, 4,   1'b0, '0}
   };

   free_list_block_allocator #(
      .BLOCK_COUNT (BLOCKS)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   function automatic rsp_type predict_pool_reply(req_type r);
      rsp_type          o;
      int unsigned      eff;
      logic [INDEX_W:0] lnk;
      o = '0;
      if (r.kind == KIND_ALLOC) begin
         if (!pool_has_free) begin
            o.status = STATUS_EMPTY;
         end else begin
            lnk = pool_link[pool_head];
            eff = (stride_reg == 0) ? 1 : ((stride_reg > STRIDE_MAX) ? STRIDE_MAX : stride_reg);
            o.status        = STATUS_GRANTED;
            o.granted_index = pool_head;
            o.byte_offset   = OFFSET_W'(int'(pool_head) * eff * 64);
            if (lnk == 0 || lnk > BLOCKS) begin
               pool_has_free = 1'b0;
               pool_head     = '0;
            end else begin
               pool_head = INDEX_W'(lnk - 1);
            end
         end
      end else begin
         o.status = STATUS_FREED;
         pool_link[r.block_index] = pool_has_free ? {1'b0, pool_head} + 1'b1 : '0;
         pool_head     = r.block_index;
         pool_has_free = 1'b1;
      end
      return o;
   endfunction

   task automatic send_request(req_type r, bit typed, rsp_type typed_reply);
      rsp_type got;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req       <= r;
      do @(posedge clock); while (!req_ready);
      requests_sent++;
      got = predict_pool_reply(r);
      if (got.status == STATUS_GRANTED) begin
         held_blocks.push_back(got.granted_index);
      end else if (r.kind == KIND_FREE) begin
         for (int k = 0; k < held_blocks.size(); k++) begin
            if (held_blocks[k] == r.block_index) begin
               held_blocks.delete(k);
               break;
            end
         end
      end
      pending_replies.push_back(typed ? typed_reply : got);
   endtask

   task automatic send_alloc();
      req_type r;
      r.kind        = KIND_ALLOC;
      r.block_index = INDEX_W'($urandom);
      send_request(r, 1'b0, '0);
   endtask

   task automatic send_free_held();
      req_type r;
      r.kind        = KIND_FREE;
      r.block_index = held_blocks[$urandom_range(held_blocks.size() - 1)];
      send_request(r, 1'b0, '0);
   endtask

   task automatic walk_script(int unsigned first, int unsigned last);
      req_type r;
      for (int unsigned i = first; i <= last; i++) begin
         r.kind        = pool_script[i].kind;
         r.block_index = pool_script[i].index;
         repeat (pool_script[i].reps) begin
            send_request(r, pool_script[i].typed, pool_script[i].reply);
         end
      end
   endtask

   task automatic drain_replies(int unsigned tail);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (tail) @(posedge clock);
   endtask

   task automatic write_stride(logic [STRIDE_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      stride_reg = value;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic run_bursts(int unsigned quota);
      int unsigned start;
      int unsigned len;
      int unsigned alloc_pct;
      start = requests_sent;
      while (requests_sent - start < quota) begin
         case ($urandom_range(9))
            0: begin
               while (pool_has_free) send_alloc();
               repeat ($urandom_range(1, 3)) send_alloc();
            end
            1: begin
               while (held_blocks.size() != 0) send_free_held();
            end
            default: begin
               len       = $urandom_range(1, 32);
               alloc_pct = $urandom_range(20, 80);
               repeat (len) begin
                  if (held_blocks.size() == 0 || $urandom_range(99) < alloc_pct) begin
                     send_alloc();
                  end else begin
                     send_free_held();
                  end
               end
            end
         endcase
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_replies.size() == 0) begin
            $error("unexpected response: status %0d index %0d offset %0d",
                   rsp.status, rsp.granted_index, rsp.byte_offset);
            mismatches++;
         end else begin
            want = pending_replies.pop_front();
            if (rsp.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp.status);
               mismatches++;
            end
            if (rsp.granted_index !== want.granted_index) begin
               $error("granted_index: expected %0d, got %0d",
                      want.granted_index, rsp.granted_index);
               mismatches++;
            end
            if (rsp.byte_offset !== want.byte_offset) begin
               $error("byte_offset: expected %0d, got %0d",
                      want.byte_offset, rsp.byte_offset);
               mismatches++;
            end
         end
      end
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   initial begin
      stride_reg    = 1;
      pool_head     = INDEX_W'(BLOCKS - 1);
      pool_has_free = 1'b1;
      for (int i = 0; i < BLOCKS; i++) pool_link[i] = (INDEX_W + 1)'(i);
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      walk_script(0, OPENING_ROWS - 1);

      drain_replies(4);
      write_stride(11'd0);
      run_bursts(PHASE_REQUESTS);

      drain_replies(4);
      write_stride(11'd2047);
      send_idle_pct = 74;
      run_bursts(PHASE_REQUESTS);

      drain_replies(4);
      write_stride(11'd1024);
      send_idle_pct  = 0;
      recv_stall_pct = 74;
      run_bursts(PHASE_REQUESTS);

      drain_replies(4);
      write_stride(11'd1025);
      send_idle_pct  = 20;
      recv_stall_pct = 20;
      run_bursts(PHASE_REQUESTS);

      drain_replies(4);
      write_stride(STRIDE_W'($urandom_range(2, 1023)));
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      run_bursts(PHASE_REQUESTS);

      drain_replies(4);
      write_stride(11'd1);
      send_idle_pct  = 20;
      recv_stall_pct = 20;
      run_bursts(PHASE_REQUESTS);

      walk_script(OPENING_ROWS, SCRIPT_ROWS - 1);
      drain_replies(8);

      if (mismatches == 0) begin
         $display("** free_list_block_allocator: PASSED **");
      end else begin
         $display("** free_list_block_allocator: FAILED **");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("** free_list_block_allocator: FAILED **");
      $finish;
   end

endmodule

@@ free_list_block_allocator.f @@
design/flba_pkg.sv
design/flba_ctrl.sv
design/flba_datapath.sv
design/free_list_block_allocator.sv
design/flba_checker.sv
test/tb_free_list_block_allocator.sv
